// ----- sv/epp_pkg.sv -----
`timescale 1ns / 1ps

package epp_pkg;

  // Width of the per-phase wait counter.
  localparam int unsigned CountBits = 16;
  localparam int unsigned LimitBits = 16;
  localparam int unsigned CmpBits   = (CountBits > LimitBits) ? CountBits : LimitBits;

  localparam logic [LimitBits-1:0] LimitReset = 16'd1000;

  localparam int unsigned InDataBits  = 24;
  localparam int unsigned OutDataBits = 40;

  // One input item after it leaves the stream port.
  typedef struct packed {
    logic       kind;
    logic       is_read;
    logic       is_address;
    logic [7:0] write_byte;
    logic       last_in_block;
    logic       wait_pin;
    logic [7:0] data_pins_in;
  } req_in_t;

  // One result item.
  typedef struct packed {
    logic [15:0] bytes_done;
    logic [7:0]  read_byte;
    logic        rejected;
    logic        timed_out;
    logic        done_res;
    logic        busy_res;
    logic        addr_strobe;
    logic        data_strobe;
    logic        write_active;
    logic        drive_data;
    logic [7:0]  data_out;
  } result_t;

endpackage

// ----- sv/epp_host_handshake.sv -----
`timescale 1ns / 1ps
// An accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while the result port is not stalled; the
// sequencer updates its state as each item leaves the input register.
// Reset (asynchronous, active low) empties both registers, idles the
// sequencer, clears the counters and sets the timeout limit to 1000.

module epp_host_handshake
  import epp_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [LimitBits-1:0]   cfg_wdata_i,
  input  logic                   s_axis_tvalid_i,
  output logic                   s_axis_tready_o,
  // is_read, is_address, write_byte[7:0], wait_pin, data_pins_in[7:0], zero fill
  input  logic [InDataBits-1:0]  s_axis_tdata_i,
  // kind
  input  logic                   s_axis_tuser_i,
  input  logic                   s_axis_tlast_i,
  output logic                   m_axis_tvalid_o,
  input  logic                   m_axis_tready_i,
  // data_out[7:0], drive_data, write_active, data_strobe, addr_strobe,
  // busy_res, done_res, timed_out, rejected, read_byte[7:0], bytes_done[15:0]
  output logic [OutDataBits-1:0] m_axis_tdata_o
);

  logic    in_valid_q;
  req_in_t in_q;
  logic    fire, obuf_ready, obuf_valid;
  result_t result, obuf_data;

  assign fire            = in_valid_q && obuf_ready;
  assign s_axis_tready_o = !in_valid_q || obuf_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_q <= '{kind:          s_axis_tuser_i,
                is_read:       s_axis_tdata_i[0],
                is_address:    s_axis_tdata_i[1],
                write_byte:    s_axis_tdata_i[9:2],
                last_in_block: s_axis_tlast_i,
                wait_pin:      s_axis_tdata_i[10],
                data_pins_in:  s_axis_tdata_i[18:11]};
    end
  end

  epp_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .fire_i      (fire),
    .req_i       (in_q),
    .result_o    (result)
  );

  epp_obuf u_obuf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .data_i  (result),
    .ready_o (obuf_ready),
    .valid_o (obuf_valid),
    .ready_i (m_axis_tready_i),
    .data_o  (obuf_data)
  );

  assign m_axis_tvalid_o = obuf_valid;
  assign m_axis_tdata_o  = obuf_data;

  // A byte cannot both complete and time out, nor be refused and complete.
  a_done_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(obuf_data.done_res && (obuf_data.timed_out || obuf_data.rejected)))
    else $error("done together with timeout or reject");

  // With the sequencer idle, no strobe and no bus drive remain.
  a_idle_pins: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !obuf_data.busy_res) |->
      !(obuf_data.drive_data || obuf_data.data_strobe || obuf_data.addr_strobe))
    else $error("pins active while idle");

  // Only one strobe line at a time.
  a_one_strobe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(obuf_data.data_strobe && obuf_data.addr_strobe))
    else $error("both strobes asserted");

  // A completion or timeout always leaves the sequencer idle.
  a_end_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (obuf_data.done_res || obuf_data.timed_out)) |-> !obuf_data.busy_res)
    else $error("busy after end of byte");

endmodule

// ----- sv/epp_core.sv -----
`timescale 1ns / 1ps

module epp_core
  import epp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [LimitBits-1:0] cfg_wdata_i,
  input  logic                 fire_i,
  input  req_in_t              req_i,
  output result_t              result_o
);

  typedef enum logic [1:0] {
    PhIdle     = 2'd0,
    PhWaitHigh = 2'd1,
    PhWaitLow  = 2'd2
  } phase_e;

  typedef struct packed {
    logic       is_read;
    logic       is_address;
    logic [7:0] wr_byte;
    logic       last;
  } latch_t;

  logic [LimitBits-1:0] limit_q;
  phase_e               phase_q, phase_d, phase_cur;
  logic [CountBits-1:0] wait_q, wait_d;
  logic [15:0]          count_q, count_d;
  logic                 aborted_q, aborted_d;
  logic                 open_q, open_d;
  latch_t               latch_q, latch_d;
  logic [7:0]           capt_q, capt_d;
  logic                 done, tmo, rej, fail, busy, wr;

  always_comb begin
    unique case (phase_q)
      PhWaitHigh: phase_cur = PhWaitHigh;
      PhWaitLow:  phase_cur = PhWaitLow;
      default:    phase_cur = PhIdle;
    endcase
  end

  // A failing tick aborts once the earlier failing ticks pass the limit,
  // or when the counter has saturated.
  assign fail = (CmpBits'(wait_q) > CmpBits'(limit_q)) || (wait_q == '1);

  always_comb begin
    phase_d   = phase_cur;
    wait_d    = wait_q;
    count_d   = count_q;
    aborted_d = aborted_q;
    open_d    = open_q;
    latch_d   = latch_q;
    capt_d    = capt_q;
    done      = 1'b0;
    tmo       = 1'b0;
    rej       = 1'b0;
    if (req_i.kind) begin
      if (phase_cur != PhIdle) begin
        rej = 1'b1;
      end else if (aborted_q) begin
        rej = 1'b1;
        if (req_i.last_in_block) begin
          aborted_d = 1'b0;
          open_d    = 1'b0;
        end
      end else begin
        latch_d = '{is_read:    req_i.is_read,
                    is_address: req_i.is_address,
                    wr_byte:    req_i.write_byte,
                    last:       req_i.last_in_block};
        if (!open_q) begin
          count_d = '0;
        end
        open_d  = 1'b1;
        phase_d = PhWaitHigh;
        wait_d  = '0;
      end
    end else begin
      if ((phase_cur == PhWaitHigh && req_i.wait_pin) ||
          (phase_cur == PhWaitLow && !req_i.wait_pin)) begin
        wait_d = '0;
        if (phase_cur == PhWaitHigh) begin
          phase_d = PhWaitLow;
        end else begin
          if (latch_q.is_read) begin
            capt_d = req_i.data_pins_in;
          end
          if (count_q != 16'hFFFF) begin
            count_d = count_q + 16'd1;
          end
          if (latch_q.last) begin
            open_d = 1'b0;
          end
          phase_d = PhIdle;
          done    = 1'b1;
        end
      end else if (phase_cur != PhIdle) begin
        if (fail) begin
          phase_d = PhIdle;
          wait_d  = '0;
          tmo     = 1'b1;
          if (latch_q.last) begin
            open_d = 1'b0;
          end else begin
            aborted_d = 1'b1;
          end
        end else begin
          wait_d = wait_q + CountBits'(1);
        end
      end
    end
  end

  assign busy = (phase_d != PhIdle);
  assign wr   = busy && !latch_d.is_read;

  always_comb begin
    result_o.data_out     = wr ? latch_d.wr_byte : 8'd0;
    result_o.drive_data   = wr;
    result_o.write_active = wr;
    result_o.data_strobe  = (phase_d == PhWaitLow) && !latch_d.is_address;
    result_o.addr_strobe  = (phase_d == PhWaitLow) && latch_d.is_address;
    result_o.busy_res     = busy;
    result_o.done_res     = done;
    result_o.timed_out    = tmo;
    result_o.rejected     = rej;
    result_o.read_byte    = capt_d;
    result_o.bytes_done   = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q   <= LimitReset;
      phase_q   <= PhIdle;
      wait_q    <= '0;
      count_q   <= '0;
      aborted_q <= 1'b0;
      open_q    <= 1'b0;
      latch_q   <= '0;
      capt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      if (fire_i) begin
        phase_q   <= phase_d;
        wait_q    <= wait_d;
        count_q   <= count_d;
        aborted_q <= aborted_d;
        open_q    <= open_d;
        latch_q   <= latch_d;
        capt_q    <= capt_d;
      end
    end
  end

endmodule

// ----- sv/epp_obuf.sv -----
`timescale 1ns / 1ps

module epp_obuf
  import epp_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    valid_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  logic    valid_q;
  result_t data_q;

  // The register takes a new item whenever it is empty or being drained.
  assign ready_o = !valid_q || ready_i;
  assign valid_o = valid_q;
  assign data_o  = data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      data_q <= data_i;
    end
  end

endmodule

// ----- tb/epp_host_handshake_test.sv -----
`timescale 1ns / 1ps

module epp_host_handshake_test;
  import epp_pkg::*;

  typedef enum logic [1:0] {
    PhIdle,
    PhWaitHigh,
    PhWaitLow
  } seq_phase_e;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   cfg_we_i = 1'b0;
  logic [LimitBits-1:0]   cfg_wdata_i = '0;
  logic                   s_axis_tvalid_i = 1'b0;
  logic                   s_axis_tready_o;
  logic [InDataBits-1:0]  s_axis_tdata_i = '0;
  logic                   s_axis_tuser_i = 1'b0;
  logic                   s_axis_tlast_i = 1'b0;
  logic                   m_axis_tvalid_o;
  logic                   m_axis_tready_i = 1'b0;
  logic [OutDataBits-1:0] m_axis_tdata_o;

  epp_host_handshake uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tuser_i (s_axis_tuser_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o)
  );

  // Shadow copy of the sequencer state, advanced once per accepted item.
  logic [LimitBits-1:0] tmo_limit   = LimitReset;
  seq_phase_e           seq_phase   = PhIdle;
  logic [CountBits-1:0] wait_ticks  = '0;
  logic [15:0]          blk_count   = '0;
  logic                 blk_aborted = 1'b0;
  logic                 blk_open    = 1'b0;
  logic                 lat_read    = 1'b0;
  logic                 lat_addr    = 1'b0;
  logic [7:0]           lat_byte    = '0;
  logic                 lat_last    = 1'b0;
  logic [7:0]           rd_byte     = '0;

  req_in_t     stimulus_items[$];
  result_t     predicted_status[$];
  req_in_t     in_flight;
  int unsigned queued_items = 0;
  int unsigned error_count = 0;
  bit          no_idle = 1'b0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #(10_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  function automatic result_t epp_step(req_in_t it);
    result_t r;
    logic    fin;
    logic    tmo;
    logic    rej;
    logic    miss;
    logic    busy;
    logic    wr;
    fin  = 1'b0;
    tmo  = 1'b0;
    rej  = 1'b0;
    miss = 1'b0;
    if (it.kind) begin
      if (seq_phase != PhIdle) begin
        rej = 1'b1;
      end else if (blk_aborted) begin
        // The byte marked last closes an aborted block even though it is refused.
        rej = 1'b1;
        if (it.last_in_block) begin
          blk_aborted = 1'b0;
          blk_open    = 1'b0;
        end
      end else begin
        lat_read = it.is_read;
        lat_addr = it.is_address;
        lat_byte = it.write_byte;
        lat_last = it.last_in_block;
        if (!blk_open) blk_count = '0;
        blk_open   = 1'b1;
        seq_phase  = PhWaitHigh;
        wait_ticks = '0;
      end
    end else if (seq_phase == PhWaitHigh) begin
      if (it.wait_pin) begin
        seq_phase  = PhWaitLow;
        wait_ticks = '0;
      end else begin
        miss = 1'b1;
      end
    end else if (seq_phase == PhWaitLow) begin
      if (!it.wait_pin) begin
        if (lat_read) rd_byte = it.data_pins_in;
        if (blk_count != 16'hFFFF) blk_count = blk_count + 16'd1;
        if (lat_last) blk_open = 1'b0;
        seq_phase  = PhIdle;
        wait_ticks = '0;
        fin        = 1'b1;
      end else begin
        miss = 1'b1;
      end
    end

    if (miss) begin
      // A full counter times out regardless of the limit.
      if (CmpBits'(wait_ticks) > CmpBits'(tmo_limit) || wait_ticks == '1) begin
        seq_phase  = PhIdle;
        wait_ticks = '0;
        if (lat_last) blk_open = 1'b0;
        else blk_aborted = 1'b1;
        tmo = 1'b1;
      end else begin
        wait_ticks = wait_ticks + CountBits'(1);
      end
    end

    busy           = (seq_phase != PhIdle);
    wr             = busy && !lat_read;
    r.data_out     = wr ? lat_byte : 8'h00;
    r.drive_data   = wr;
    r.write_active = wr;
    r.data_strobe  = (seq_phase == PhWaitLow) && !lat_addr;
    r.addr_strobe  = (seq_phase == PhWaitLow) && lat_addr;
    r.busy_res     = busy;
    r.done_res     = fin;
    r.timed_out    = tmo;
    r.rejected     = rej;
    r.read_byte    = rd_byte;
    r.bytes_done   = blk_count;
    return r;
  endfunction

  task automatic push_item(req_in_t it);
    stimulus_items.push_back(it);
    queued_items++;
  endtask

  // Request fields of a tick and pin fields of a request are random filler.
  task automatic push_tick(logic pin, logic [7:0] pins);
    req_in_t it;
    it               = req_in_t'($urandom);
    it.kind          = 1'b0;
    it.wait_pin      = pin;
    it.data_pins_in  = pins;
    push_item(it);
  endtask

  task automatic push_req(logic rd, logic ad, logic [7:0] wbyte, logic last);
    req_in_t it;
    it               = req_in_t'($urandom);
    it.kind          = 1'b1;
    it.is_read       = rd;
    it.is_address    = ad;
    it.write_byte    = wbyte;
    it.last_in_block = last;
    push_item(it);
  endtask

  // Failing ticks for one wait phase, weighted toward the timeout boundary.
  function automatic int unsigned pick_misses(int unsigned lim);
    case ($urandom_range(9))
      0:       return lim + 1;
      1:       return lim + 2;
      default: return $urandom_range((lim < 4) ? lim : 4);
    endcase
  endfunction

  task automatic push_transfer(int unsigned lim);
    push_req(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
             $urandom_range(3) == 0);
    repeat (pick_misses(lim)) push_tick(1'b0, 8'($urandom_range(255)));
    push_tick(1'b1, 8'($urandom_range(255)));
    if ($urandom_range(9) == 0) begin
      push_req(1'($urandom_range(1)), 1'($urandom_range(1)), 8'($urandom_range(255)),
               1'($urandom_range(1)));
    end
    repeat (pick_misses(lim)) push_tick(1'b1, 8'($urandom_range(255)));
    push_tick(1'b0, 8'($urandom_range(255)));
  endtask

  task automatic run_random(int unsigned lim, int unsigned count);
    int unsigned stop_at;
    stop_at = queued_items + count;
    while (queued_items < stop_at) begin
      if ($urandom_range(99) < 15) push_item(req_in_t'($urandom));
      else push_transfer(lim);
    end
  endtask

  task automatic wait_for_idle();
    wait (stimulus_items.size() == 0 && !s_axis_tvalid_i && predicted_status.size() == 0);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_timeout_limit(logic [LimitBits-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    tmo_limit = value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  task automatic compare_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, want, got);
      error_count++;
    end
  endtask

  // Driver: the item on the bus is predicted at the edge that accepts it.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid_i && s_axis_tready_o) begin
        predicted_status.push_back(epp_step(in_flight));
      end
      if (!s_axis_tvalid_i || s_axis_tready_o) begin
        if (stimulus_items.size() != 0 && (no_idle || $urandom_range(99) >= 33)) begin
          in_flight = stimulus_items.pop_front();
          s_axis_tvalid_i <= 1'b1;
          s_axis_tuser_i  <= in_flight.kind;
          s_axis_tlast_i  <= in_flight.last_in_block;
          s_axis_tdata_i  <= {5'b0, in_flight.data_pins_in, in_flight.wait_pin,
                              in_flight.write_byte, in_flight.is_address, in_flight.is_read};
        end else begin
          s_axis_tvalid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: every result is checked against the oldest prediction.
  always @(posedge clk_i) begin
    result_t got;
    result_t want;
    if (rst_ni) begin
      if (m_axis_tvalid_o && m_axis_tready_i) begin
        got = result_t'(m_axis_tdata_o);
        if (predicted_status.size() == 0) begin
          $display("%0t: result mismatch, expected none, got %0h", $time, got);
          error_count++;
        end else begin
          want = predicted_status.pop_front();
          compare_field("data_out", 16'(want.data_out), 16'(got.data_out));
          compare_field("drive_data", 16'(want.drive_data), 16'(got.drive_data));
          compare_field("write_active", 16'(want.write_active), 16'(got.write_active));
          compare_field("data_strobe", 16'(want.data_strobe), 16'(got.data_strobe));
          compare_field("addr_strobe", 16'(want.addr_strobe), 16'(got.addr_strobe));
          compare_field("busy_res", 16'(want.busy_res), 16'(got.busy_res));
          compare_field("done_res", 16'(want.done_res), 16'(got.done_res));
          compare_field("timed_out", 16'(want.timed_out), 16'(got.timed_out));
          compare_field("rejected", 16'(want.rejected), 16'(got.rejected));
          compare_field("read_byte", 16'(want.read_byte), 16'(got.read_byte));
          compare_field("bytes_done", want.bytes_done, got.bytes_done);
        end
      end
      m_axis_tready_i <= no_idle || ($urandom_range(99) >= 33);
    end
  end

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part with the reset limit: idle tick, write, busy request, reads, address write.
    push_tick(1'b1, 8'hFF);
    push_req(1'b0, 1'b0, 8'hFF, 1'b0);
    push_tick(1'b0, 8'h00);
    push_tick(1'b1, 8'h00);
    push_req(1'b1, 1'b1, 8'h00, 1'b1);
    push_tick(1'b1, 8'hFF);
    push_tick(1'b0, 8'hFF);
    push_req(1'b1, 1'b1, 8'h00, 1'b0);
    push_tick(1'b1, 8'h00);
    push_tick(1'b0, 8'hFF);
    push_req(1'b1, 1'b0, 8'hFF, 1'b1);
    push_tick(1'b1, 8'hFF);
    push_tick(1'b0, 8'h00);
    push_req(1'b0, 1'b1, 8'h5A, 1'b0);
    push_tick(1'b1, 8'hA5);
    push_tick(1'b0, 8'h5A);
    wait_for_idle();

    // Timeouts with the smallest limit: aborted block, then a timeout on a last byte.
    set_timeout_limit(16'd0);
    push_req(1'b0, 1'b0, 8'hC3, 1'b0);
    push_tick(1'b0, 8'h00);
    push_tick(1'b0, 8'h00);
    push_req(1'b1, 1'b1, 8'h11, 1'b0);
    push_req(1'b0, 1'b0, 8'h22, 1'b1);
    push_req(1'b1, 1'b0, 8'h33, 1'b1);
    push_tick(1'b1, 8'h44);
    push_tick(1'b1, 8'h55);
    push_tick(1'b1, 8'h66);
    push_req(1'b0, 1'b0, 8'h77, 1'b0);
    push_tick(1'b1, 8'h88);
    push_tick(1'b0, 8'h99);

    // Back-to-back traffic with both sides always ready.
    no_idle = 1'b1;
    run_random(0, 250);
    wait_for_idle();
    no_idle = 1'b0;

    set_timeout_limit(16'd1);
    run_random(1, 250);
    wait_for_idle();

    set_timeout_limit(16'd3);
    run_random(3, 250);
    wait_for_idle();
    run_random(3, 150);
    wait_for_idle();

    set_timeout_limit(16'd20);
    run_random(20, 300);
    wait_for_idle();

    begin
      int unsigned lim;
      lim = $urandom_range(12, 2);
      set_timeout_limit(lim[LimitBits-1:0]);
      run_random(lim, 250);
      wait_for_idle();
    end

    // With the largest limit a long wait phase still ends in a completion.
    set_timeout_limit(16'hFFFF);
    no_idle = 1'b1;
    push_req(1'b0, 1'b1, 8'h81, 1'b0);
    repeat (150) push_tick(1'b0, 8'($urandom_range(255)));
    push_tick(1'b0, 8'h00);
    push_req(1'b1, 1'b0, 8'h00, 1'b1);
    push_req(1'b1, 1'b0, 8'h00, 1'b0);
    push_tick(1'b1, 8'h3C);
    push_tick(1'b0, 8'hC3);
    wait_for_idle();
    no_idle = 1'b0;

    repeat (10) @(posedge clk_i);
    if (error_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
